// File: rtl/aesk_pkg.sv
`default_nettype none
package aesk_pkg;

   localparam int NumRounds = 10;
   localparam int KeyIdxLow = 0;
   localparam int KeyIdxHigh = 1;

   typedef logic [127:0] block_type;

   // Control that travels with each block down the row of round cells.
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] t [256];
      t = '{
         8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
         8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
         8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
         8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
         8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
         8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
         8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
         8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
         8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
         8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
         8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
         8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
         8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
         8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
         8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
         8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[a];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] rcon(input logic [3:0] r);
      logic [7:0] v;
      unique case (r)
         4'd1: v = 8'h01;
         4'd2: v = 8'h02;
         4'd3: v = 8'h04;
         4'd4: v = 8'h08;
         4'd5: v = 8'h10;
         4'd6: v = 8'h20;
         4'd7: v = 8'h40;
         4'd8: v = 8'h80;
         4'd9: v = 8'h1b;
         4'd10: v = 8'h36;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/aes128_ctr_keystream.sv
`default_nettype none
// Structure: one whitening stage and ten round cells, each registered, lie between
// an accepted request beat and its response beat. Throughput: one block per cycle;
// the whole row of cells stalls only while the output holds an untaken beat.
// Key schedule: after a key write, new round keys ripple down the registered key cells, one cell each.
// Reset (synchronous, active high) clears all valid flags and the key halves.
module aes128_ctr_keystream (
   input  wire  logic         clock,
   input  wire  logic         reset,
   input  wire  logic         csr_we,
   input  wire  logic         csr_index,
   input  wire  logic [63:0]  csr_wdata,
   input  wire  logic         req_tvalid,
   output       logic         req_tready,
   input  wire  logic [31:0]  req_tdata,   // counter
   input  wire  logic         req_tlast,   // last_block
   output       logic         rsp_tvalid,
   input  wire  logic         rsp_tready,
   output       logic [127:0] rsp_tdata,   // keystream_lo, keystream_hi
   output       logic         rsp_tlast    // last
);
   import aesk_pkg::*;

   logic [63:0] key_low_ff, key_high_ff;
   block_type   rk [NumRounds + 1];
   block_type   st [NumRounds + 1];
   tag_type     tg [NumRounds + 1];
   block_type   st0_ff;
   tag_type     tg0_ff;
   logic        advance;

   // Key halves.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff  <= '0;
         key_high_ff <= '0;
      end else if (csr_we) begin
         if (csr_index == 1'(KeyIdxLow)) begin
            key_low_ff <= csr_wdata;
         end else begin
            key_high_ff <= csr_wdata;
         end
      end
   end

   assign rk[0] = {key_high_ff, key_low_ff};

   // The pipeline moves whenever the last stage is empty or being taken.
   assign advance    = !tg[NumRounds].valid || rsp_tready;
   assign req_tready = advance;

   // Whitening stage: counter block xor round key 0.
   always_ff @(posedge clock) begin
      if (reset) begin
         tg0_ff <= '0;
      end else if (advance) begin
         tg0_ff <= '{valid: req_tvalid, last: req_tlast};
      end
      if (advance) begin
         st0_ff <= {96'd0, req_tdata} ^ rk[0];
      end
   end
   assign st[0] = st0_ff;
   assign tg[0] = tg0_ff;

   for (genvar r = 1; r <= NumRounds; r++) begin : g_round
      aesk_key_cell #(.Round(4'(r))) u_key (
         .clock     (clock),
         .load      (1'b1),
         .prev_key  (rk[r-1]),
         .round_key (rk[r])
      );
      aesk_round_cell #(.Final(r == NumRounds)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .state_i   (st[r-1]),
         .tag_i     (tg[r-1]),
         .round_key (rk[r]),
         .state_o   (st[r]),
         .tag_o     (tg[r])
      );
   end

   assign rsp_tvalid = tg[NumRounds].valid;
   assign rsp_tlast  = tg[NumRounds].last;
   assign rsp_tdata  = st[NumRounds];
endmodule
`default_nettype wire

// File: rtl/aesk_key_cell.sv
`default_nettype none
// One step of the key schedule: next round key from the previous one.
module aesk_key_cell #(
   parameter logic [3:0] Round = 4'd1
) (
   input  wire  logic                 clock,
   input  wire  logic                 load,
   input  wire  aesk_pkg::block_type  prev_key,
   output       aesk_pkg::block_type  round_key
);
   import aesk_pkg::*;

   block_type key_ff;
   block_type key_in;
   logic [7:0] t [4];

   // Rotated, substituted last word plus round constant.
   always_comb begin
      t[0] = sbox(prev_key[111:104]) ^ rcon(Round);
      t[1] = sbox(prev_key[119:112]);
      t[2] = sbox(prev_key[127:120]);
      t[3] = sbox(prev_key[103:96]);
      key_in[31:0]   = prev_key[31:0] ^ {t[3], t[2], t[1], t[0]};
      key_in[63:32]  = prev_key[63:32] ^ key_in[31:0];
      key_in[95:64]  = prev_key[95:64] ^ key_in[63:32];
      key_in[127:96] = prev_key[127:96] ^ key_in[95:64];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         key_ff <= key_in;
      end
   end

   assign round_key = key_ff;
endmodule
`default_nettype wire

// File: rtl/aesk_round_cell.sv
`default_nettype none
// One AES round as a pipeline cell; the final cell skips MixColumns.
module aesk_round_cell #(
   parameter bit Final = 1'b0
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 advance,
   input  wire  aesk_pkg::block_type  state_i,
   input  wire  aesk_pkg::tag_type    tag_i,
   input  wire  aesk_pkg::block_type  round_key,
   output       aesk_pkg::block_type  state_o,
   output       aesk_pkg::tag_type    tag_o
);
   import aesk_pkg::*;

   block_type state_ff, state_in;
   tag_type   tag_ff;
   logic [7:0] s [16];
   logic [7:0] m [16];

   always_comb begin
      // SubBytes and ShiftRows.
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            s[r + 4 * c] = sbox(state_i[8 * (r + 4 * ((c + r) % 4)) +: 8]);
         end
      end
      // MixColumns.
      for (int c = 0; c < 4; c++) begin
         m[4*c]   = s[4*c]   ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3]
                    ^ xtime(s[4*c] ^ s[4*c+1]);
         m[4*c+1] = s[4*c+1] ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3]
                    ^ xtime(s[4*c+1] ^ s[4*c+2]);
         m[4*c+2] = s[4*c+2] ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3]
                    ^ xtime(s[4*c+2] ^ s[4*c+3]);
         m[4*c+3] = s[4*c+3] ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3]
                    ^ xtime(s[4*c+3] ^ s[4*c]);
      end
      for (int i = 0; i < 16; i++) begin
         state_in[8*i +: 8] = (Final ? s[i] : m[i]) ^ round_key[8*i +: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (advance) begin
         tag_ff <= tag_i;
      end
      if (advance) begin
         state_ff <= state_in;
      end
   end

   assign state_o = state_ff;
   assign tag_o   = tag_ff;
endmodule
`default_nettype wire

// File: sim/aes128_ctr_keystream_tb.sv
`default_nettype none
module aes128_ctr_keystream_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import aesk_pkg::*;

   typedef struct {
      logic [63:0] ks_lo;
      logic [63:0] ks_hi;
      logic        last;
   } keystream_beat;

   typedef struct {
      logic [31:0] counter;
      logic        last;
      logic        chk;
      logic [63:0] ks_lo;
      logic [63:0] ks_hi;
   } vector_row;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [63:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [31:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic         rsp_tlast;

   logic [7:0]    sb [256];
   logic [127:0]  round_key [11];
   logic [63:0]   key_lo_q = '0;
   logic [63:0]   key_hi_q = '0;
   keystream_beat pending_ks [$];
   int            mismatches = 0;
   int            blocks_sent = 0;
   int            blocks_seen = 0;
   int            hold_cycles = 0;
   bit            no_idle = 1'b0;

   always #10 clock = ~clock;

   aes128_ctr_keystream dut (.*);

   // The S-box is built from its algebraic definition: inverse in GF(2^8) then affine map.
   function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] p;
      p = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return p;
   endfunction

   function automatic logic [7:0] dbl(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   task automatic build_sbox();
      logic [7:0] inv, v;
      for (int x = 0; x < 256; x++) begin
         inv = '0;
         for (int y = 1; y < 256; y++)
            if (gf_mul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
         v = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
             ^ {inv[3:0], inv[7:4]} ^ 8'h63;
         sb[x] = v;
      end
   endtask

   // Standard AES-128 key schedule over byte-lane-ordered words (byte 0 in bits 7:0).
   task automatic expand_schedule();
      logic [31:0] w [44];
      logic [31:0] t;
      logic [7:0]  rc;
      rc = 8'h01;
      for (int i = 0; i < 4; i++) w[i] = (i < 2) ? key_lo_q[32*i +: 32] : key_hi_q[32*(i-2) +: 32];
      for (int i = 4; i < 44; i++) begin
         t = w[i-1];
         if (i % 4 == 0) begin
            t = {sb[t[7:0]], sb[t[31:24]], sb[t[23:16]], sb[t[15:8]] ^ rc};
            rc = dbl(rc);
         end
         w[i] = w[i-4] ^ t;
      end
      for (int r = 0; r < 11; r++) round_key[r] = {w[4*r+3], w[4*r+2], w[4*r+1], w[4*r]};
   endtask

   function automatic logic [127:0] encrypt_counter(logic [31:0] ctr);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, al;
      logic [127:0] blk;
      blk = {96'b0, ctr} ^ round_key[0];
      for (int r = 1; r <= 10; r++) begin
         for (int i = 0; i < 16; i++) s[i] = blk[8*i +: 8];
         for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++) t[row + 4*c] = sb[s[row + 4*((c + row) % 4)]];
         if (r < 10)
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               al = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ al ^ dbl(a0 ^ a1);
               t[4*c+1] = a1 ^ al ^ dbl(a1 ^ a2);
               t[4*c+2] = a2 ^ al ^ dbl(a2 ^ a3);
               t[4*c+3] = a3 ^ al ^ dbl(a3 ^ a0);
            end
         for (int i = 0; i < 16; i++) blk[8*i +: 8] = t[i];
         blk ^= round_key[r];
      end
      return blk;
   endfunction

   task automatic write_key(logic idx, logic [63:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == 1'(KeyIdxLow)) key_lo_q = val; else key_hi_q = val;
      expand_schedule();
      // Let the round keys ripple through every cell.
      repeat (16) @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_ks.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // One request beat; the expectation is queued at the accepting edge.
   task automatic send_block(logic [31:0] ctr, logic lst);
      logic [127:0] ks;
      while (!no_idle && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= ctr;
      req_tlast <= lst;
      do @(posedge clock); while (!req_tready);
      ks = encrypt_counter(ctr);
      pending_ks.push_back('{ks[63:0], ks[127:64], lst});
      blocks_sent++;
      @(negedge clock);
   endtask

   // Response side: random stalls, plus a long hold-off when requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else
         rsp_tready <= no_idle || ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      keystream_beat exp_ks;
      if (!reset && rsp_tvalid && rsp_tready) begin
         blocks_seen++;
         if (pending_ks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected keystream beat %h", rsp_tdata);
         end else begin
            exp_ks = pending_ks.pop_front();
            if (rsp_tdata !== {exp_ks.ks_hi, exp_ks.ks_lo} || rsp_tlast !== exp_ks.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("keystream mismatch: exp %h/%h last %b, got %h last %b",
                           exp_ks.ks_hi, exp_ks.ks_lo, exp_ks.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   initial begin
      #100ms;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      vector_row vectors [$];
      logic [127:0] fixed_ks;
      build_sbox();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // All-zero key: encrypting an all-zero block gives the well-known 66e94bd4... result.
      write_key(1'(KeyIdxLow), 64'h0);
      write_key(1'(KeyIdxHigh), 64'h0);
      vectors.push_back('{32'h0, 1'b0, 1'b1, 64'h3b2c8aefd44be966, 64'h2e2b34ca59fa4c88});
      vectors.push_back('{32'hffffffff, 1'b1, 1'b0, '0, '0});
      vectors.push_back('{32'h00000001, 1'b0, 1'b0, '0, '0});
      vectors.push_back('{32'h80000000, 1'b1, 1'b0, '0, '0});
      vectors.push_back('{32'h55aa55aa, 1'b0, 1'b0, '0, '0});
      vectors.push_back('{32'haa55aa55, 1'b1, 1'b0, '0, '0});
      foreach (vectors[i]) begin
         if (vectors[i].chk) begin
            fixed_ks = encrypt_counter(vectors[i].counter);
            if (fixed_ks !== {vectors[i].ks_hi, vectors[i].ks_lo}) begin
               mismatches++;
               $display("schedule model disagrees with known vector: %h", fixed_ks);
            end
         end
         send_block(vectors[i].counter, vectors[i].last);
      end
      drain();

      // All-ones key, then random keys; each phase sends a run of blocks.
      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 0) begin
            write_key(1'(KeyIdxLow), '1);
            write_key(1'(KeyIdxHigh), '1);
         end else begin
            write_key(1'(KeyIdxLow), {$urandom, $urandom});
            if ($urandom_range(1)) write_key(1'(KeyIdxHigh), {$urandom, $urandom});
         end
         no_idle = (phase == 3);
         if (phase == 5) hold_cycles = 200;
         for (int n = 0; n < 200; n++)
            send_block($urandom, $urandom_range(7) == 0);
         if (phase == 2) drain();
         drain();
      end
      no_idle = 1'b0;
      drain();

      $display("Covered %0d keystream blocks under nine key settings, %0d responses checked.",
               blocks_sent, blocks_seen);
      if (mismatches == 0 && pending_ks.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
rtl/aesk_pkg.sv
rtl/aesk_key_cell.sv
rtl/aesk_round_cell.sv
rtl/aes128_ctr_keystream.sv
sim/aes128_ctr_keystream_tb.sv
